/* rtl/core/rbhs_pkg.sv */
// ----------------------------------------------------------------------------
// Raster height sampler package
// Shared widths, codes, reset values and a small helper for the sampler.
// ----------------------------------------------------------------------------
package rbhs_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int FRAC_ONE   = 'h100;
  localparam int PROD_SHIFT = 16;

  localparam int POS_W      = 17;
  localparam int HGT_W      = 16;
  localparam int SIZE_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SIZE_W-1:0]       GRID_SIZE_RESET = 10'd512;
  localparam logic signed [HGT_W-1:0] THRESHOLD_RESET = -16'sd30000;
  localparam logic signed [HGT_W-1:0] INVALID_HEIGHT  = 16'sh8000;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH        = 2'd0,
    CFG_GRID_HEIGHT       = 2'd1,
    CFG_SPECIAL_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Effective grid size and threshold as seen by the datapath.
  typedef struct packed {
    logic [SIZE_W-1:0]       grid_w;
    logic [SIZE_W-1:0]       grid_h;
    logic signed [HGT_W-1:0] threshold;
  } cfg_t;

  // Query context that travels alongside the bank read data.
  typedef struct packed {
    logic                 in_range;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic                 cxp;
    logic                 cyp;
    logic                 nxp;
    logic                 nyp;
  } fetch_t;

  // A size of zero acts as one; a size above the array limit acts as the limit.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input int unsigned maxv);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (32'(v) > maxv) begin
      res = SIZE_W'(maxv);
    end
    return res;
  endfunction

endpackage

/* rtl/core/rbhs_if.sv */
// ----------------------------------------------------------------------------
// Raster height sampler channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface rbhs_in_if;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [16:0]              pos_x;
  logic [16:0]              pos_y;
  logic signed [15:0]       write_height;

  modport source (output valid, opcode, pos_x, pos_y, write_height, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, write_height, output ready);
endinterface

interface rbhs_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       height;
  logic                     in_range;

  modport source (output valid, height, in_range, input ready);
  modport sink   (input valid, height, in_range, output ready);
endinterface

/* rtl/core/rbhs_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module rbhs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/rbhs_cfg.sv */
// ----------------------------------------------------------------------------
// Raster height sampler configuration
// Holds grid size (already clamped to the array limits) and the threshold.
// ----------------------------------------------------------------------------
module rbhs_cfg #(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rbhs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbhs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output rbhs_pkg::cfg_t                      cfg
);

  rbhs_pkg::cfg_t cfg_r;
  rbhs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rbhs_pkg::CFG_GRID_WIDTH: begin
          cfg_nxt.grid_w = rbhs_pkg::eff_size(cfg_wdata[rbhs_pkg::SIZE_W-1:0],
                                              MAX_COLUMNS);
        end
        rbhs_pkg::CFG_GRID_HEIGHT: begin
          cfg_nxt.grid_h = rbhs_pkg::eff_size(cfg_wdata[rbhs_pkg::SIZE_W-1:0],
                                              MAX_ROWS);
        end
        rbhs_pkg::CFG_SPECIAL_THRESHOLD: begin
          cfg_nxt.threshold = $signed(cfg_wdata[rbhs_pkg::HGT_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_w    <= rbhs_pkg::eff_size(rbhs_pkg::GRID_SIZE_RESET, MAX_COLUMNS);
      cfg_r.grid_h    <= rbhs_pkg::eff_size(rbhs_pkg::GRID_SIZE_RESET, MAX_ROWS);
      cfg_r.threshold <= rbhs_pkg::THRESHOLD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/rbhs_fetch.sv */
// ----------------------------------------------------------------------------
// Raster height sampler fetch stage
// Decodes a beat, writes a cell or reads the four neighbors from four banks
// split by column and row parity.
// ----------------------------------------------------------------------------
module rbhs_fetch #(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rbhs_in_if.sink                              in_ch,
  input  rbhs_pkg::cfg_t                       cfg,
  input  logic                                 s1_ready,
  output logic                                 s1_valid,
  output rbhs_pkg::fetch_t                     s1_info,
  output logic signed [rbhs_pkg::HGT_W-1:0]    s1_cell [4]
);

  localparam int CH         = (MAX_COLUMNS + 1) / 2;
  localparam int RH         = (MAX_ROWS + 1) / 2;
  localparam int CHW        = (CH > 1) ? $clog2(CH) : 1;
  localparam int RHW        = (RH > 1) ? $clog2(RH) : 1;
  localparam int AW         = CHW + RHW;
  localparam int BANK_DEPTH = 2 ** AW;
  localparam int SW         = rbhs_pkg::SIZE_W;

  logic             accept;
  logic             is_query;
  logic [SW-1:0]    cx, cy, nx, ny;
  logic [SW-1:0]    wcol, wrow;
  logic             q_in_range;
  logic             w_in_grid;
  logic             s1_valid_r;
  rbhs_pkg::fetch_t info_r;
  rbhs_pkg::fetch_t info_nxt;

  assign in_ch.ready = !s1_valid_r || s1_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_query    = (in_ch.opcode == rbhs_pkg::OP_QUERY);

  assign cx = SW'(in_ch.pos_x >> rbhs_pkg::FRAC_BITS);
  assign cy = SW'(in_ch.pos_y >> rbhs_pkg::FRAC_BITS);
  assign q_in_range = (cx < cfg.grid_w) && (cy < cfg.grid_h);

  // The right and lower neighbors clamp at the last used column and row.
  assign nx = (cx == cfg.grid_w - SW'(1)) ? cx : cx + SW'(1);
  assign ny = (cy == cfg.grid_h - SW'(1)) ? cy : cy + SW'(1);

  assign wcol      = in_ch.pos_x[SW-1:0];
  assign wrow      = in_ch.pos_y[SW-1:0];
  assign w_in_grid = (in_ch.pos_x < rbhs_pkg::POS_W'(cfg.grid_w)) &&
                     (in_ch.pos_y < rbhs_pkg::POS_W'(cfg.grid_h));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = 1'(b % 2);
    localparam logic BY = 1'(b / 2);

    logic [SW-1:0] col;
    logic [SW-1:0] row;
    logic [AW-1:0] addr;
    logic          we;

    // Each bank holds one parity of column and row, so the four neighbors
    // of a query always land in different banks unless clamped together.
    always_comb begin
      if (is_query) begin
        col = (cx[0] == BX) ? cx : nx;
        row = (cy[0] == BY) ? cy : ny;
      end else begin
        col = wcol;
        row = wrow;
      end
    end

    assign addr = {RHW'(row >> 1), CHW'(col >> 1)};
    assign we   = accept && !is_query && w_in_grid && (wcol[0] == BX) &&
                  (wrow[0] == BY);

    rbhs_ram #(
      .WIDTH (rbhs_pkg::HGT_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (we),
      .re    (accept && is_query),
      .addr  (addr),
      .wdata (in_ch.write_height),
      .rdata (s1_cell[b])
    );
  end

  always_comb begin
    info_nxt.in_range = q_in_range;
    info_nxt.fx       = in_ch.pos_x[rbhs_pkg::FRAC_BITS-1:0];
    info_nxt.fy       = in_ch.pos_y[rbhs_pkg::FRAC_BITS-1:0];
    info_nxt.cxp      = cx[0];
    info_nxt.cyp      = cy[0];
    info_nxt.nxp      = nx[0];
    info_nxt.nyp      = ny[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= accept && is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      info_r <= info_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_info  = info_r;

endmodule

/* rtl/core/rbhs_blend.sv */
// ----------------------------------------------------------------------------
// Raster height sampler blend pipeline
// Weights the four neighbors along x, then along y, sums and selects the final
// height. Every stage holds its beat while the next one is full and stalled.
// ----------------------------------------------------------------------------
module rbhs_blend (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rbhs_pkg::cfg_t                       cfg,
  input  logic                                 s1_valid,
  input  rbhs_pkg::fetch_t                     s1_info,
  input  logic signed [rbhs_pkg::HGT_W-1:0]    s1_cell [4],
  output logic                                 s1_ready,
  rbhs_out_if.source                           out_ch
);

  localparam int HW  = rbhs_pkg::HGT_W;
  localparam int FB  = rbhs_pkg::FRAC_BITS;
  localparam int WW  = FB + 1;
  localparam int P1W = HW + WW + 1;
  localparam int P2W = P1W + WW + 1;

  logic en2, en3, en4, en_out;

  // Stage 2: neighbor routing, threshold test, x weighting.
  logic signed [HW-1:0]  a_nxt, b_nxt, c_nxt, d_nxt;
  logic [WW-1:0]         kx, ky_nxt;
  logic signed [P1W-1:0] pa_nxt, pb_nxt, pc_nxt, pd_nxt;
  logic                  special_nxt;

  logic                  v2_r;
  logic signed [P1W-1:0] pa_r, pb_r, pc_r, pd_r;
  logic [WW-1:0]         ky2_r;
  logic [FB-1:0]         fy2_r;
  logic                  special2_r, rng2_r;
  logic signed [HW-1:0]  base2_r;

  // Stage 3: row sums.
  logic signed [P1W-1:0] top_nxt, bot_nxt;
  logic                  v3_r;
  logic signed [P1W-1:0] top_r, bot_r;
  logic [WW-1:0]         ky3_r;
  logic [FB-1:0]         fy3_r;
  logic                  special3_r, rng3_r;
  logic signed [HW-1:0]  base3_r;

  // Stage 4: y weighting.
  logic signed [P2W-1:0] mt_nxt, mb_nxt;
  logic                  v4_r;
  logic signed [P2W-1:0] mt_r, mb_r;
  logic                  special4_r, rng4_r;
  logic signed [HW-1:0]  base4_r;

  // Output register.
  logic signed [P2W-1:0] sum_nxt;
  logic signed [HW-1:0]  height_nxt;
  logic                  out_v_r;
  logic signed [HW-1:0]  height_r;
  logic                  rng_out_r;

  assign en_out   = !out_v_r || out_ch.ready;
  assign en4      = !v4_r || en_out;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign s1_ready = en2;

  always_comb begin
    a_nxt  = s1_cell[{s1_info.cyp, s1_info.cxp}];
    b_nxt  = s1_cell[{s1_info.cyp, s1_info.nxp}];
    c_nxt  = s1_cell[{s1_info.nyp, s1_info.cxp}];
    d_nxt  = s1_cell[{s1_info.nyp, s1_info.nxp}];
    kx     = WW'(rbhs_pkg::FRAC_ONE) - {1'b0, s1_info.fx};
    ky_nxt = WW'(rbhs_pkg::FRAC_ONE) - {1'b0, s1_info.fy};
    pa_nxt = a_nxt * $signed({1'b0, kx});
    pb_nxt = b_nxt * $signed({2'b0, s1_info.fx});
    pc_nxt = c_nxt * $signed({1'b0, kx});
    pd_nxt = d_nxt * $signed({2'b0, s1_info.fx});
    special_nxt = (a_nxt <= cfg.threshold) || (b_nxt <= cfg.threshold) ||
                  (c_nxt <= cfg.threshold) || (d_nxt <= cfg.threshold);
  end

  assign top_nxt = pa_r + pb_r;
  assign bot_nxt = pc_r + pd_r;

  assign mt_nxt = top_r * $signed({1'b0, ky3_r});
  assign mb_nxt = bot_r * $signed({2'b0, fy3_r});

  // The slice above the shift is a floor of the weighted sum.
  always_comb begin
    sum_nxt = mt_r + mb_r;
    if (!rng4_r) begin
      height_nxt = rbhs_pkg::INVALID_HEIGHT;
    end else if (special4_r) begin
      height_nxt = base4_r;
    end else begin
      height_nxt = sum_nxt[rbhs_pkg::PROD_SHIFT +: HW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en2) begin
        v2_r <= s1_valid;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en_out) begin
        out_v_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      pa_r       <= pa_nxt;
      pb_r       <= pb_nxt;
      pc_r       <= pc_nxt;
      pd_r       <= pd_nxt;
      ky2_r      <= ky_nxt;
      fy2_r      <= s1_info.fy;
      special2_r <= special_nxt;
      rng2_r     <= s1_info.in_range;
      base2_r    <= a_nxt;
    end
    if (en3 && v2_r) begin
      top_r      <= top_nxt;
      bot_r      <= bot_nxt;
      ky3_r      <= ky2_r;
      fy3_r      <= fy2_r;
      special3_r <= special2_r;
      rng3_r     <= rng2_r;
      base3_r    <= base2_r;
    end
    if (en4 && v3_r) begin
      mt_r       <= mt_nxt;
      mb_r       <= mb_nxt;
      special4_r <= special3_r;
      rng4_r     <= rng3_r;
      base4_r    <= base3_r;
    end
    if (en_out && v4_r) begin
      height_r  <= height_nxt;
      rng_out_r <= rng4_r;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.height   = height_r;
  assign out_ch.in_range = rng_out_r;

endmodule

/* rtl/core/raster_bilinear_height_sampler.sv */
// ----------------------------------------------------------------------------
// Raster bilinear height sampler
// Height grid store with a bilinear query pipeline.
// ----------------------------------------------------------------------------
// The block takes one beat per clock, write or query, unless the result side
// stalls, and returns one result beat per query; writes give no result. The
// rate holds because the grid sits in four single-port RAM banks split by
// column and row parity, so each bank serves one access a cycle and a query's
// four neighbors come from four banks at once. Stalls on the result side hold
// every stage in place while bubbles still fill. The grid has no clearing
// pass: a cell must be written before a query touches it. The user must write
// configuration only while the block is idle; the block does not enforce it.
module raster_bilinear_height_sampler #(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rbhs_in_if.sink                          in_ch,
  rbhs_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [rbhs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbhs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  rbhs_pkg::cfg_t                       cfg;
  logic                                 s1_valid;
  logic                                 s1_ready;
  rbhs_pkg::fetch_t                     s1_info;
  logic signed [rbhs_pkg::HGT_W-1:0]    s1_cell [4];

  rbhs_cfg #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rbhs_fetch #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_fetch (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .s1_ready (s1_ready),
    .s1_valid (s1_valid),
    .s1_info  (s1_info),
    .s1_cell  (s1_cell)
  );

  rbhs_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_info  (s1_info),
    .s1_cell  (s1_cell),
    .s1_ready (s1_ready),
    .out_ch   (out_ch)
  );

endmodule
